// ----- rtl/core/rkd_pkg.sv -----
// Package for the recent-key dedup table: shared types, reset values and codes.
// Used by rkd_cell and recent_key_dedup_table_top; depends on nothing else.
`default_nettype none

package rkd_pkg;

    localparam int ENTRIES_DEF = 8;

    localparam int KEY_W   = 64;
    localparam int STAMP_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [STAMP_W-1:0] WINDOW_RST = 32'd10000;

    // Register index as seen in paddr[PADDR_W-1:2].
    localparam logic REG_WINDOW = 1'b0;

    // Search wave handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               seen;
        logic [STAMP_W-1:0] stamp;
    } t_wave;

    // Write-back command broadcast to all cells.
    typedef struct packed {
        logic               en;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_upd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/rkd_cell.sv -----
// One table entry of the dedup table: holds a key and its stamp, and updates the search wave.
// Depends on rkd_pkg.
`default_nettype none

module rkd_cell
    import rkd_pkg::*;
#(
    parameter int IDX_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire t_wave            i_wave,
    input  wire logic [IDX_W-1:0] i_idx,
    output t_wave                 o_wave,
    output logic [IDX_W-1:0]      o_idx,
    input  wire t_upd             i_upd,
    input  wire logic [IDX_W-1:0] i_upd_idx
);

    logic [KEY_W-1:0]   r_key;
    logic [STAMP_W-1:0] r_stamp;
    t_wave              r_wave;
    t_wave              n_wave;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               match;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    assign match = (r_key != '0) && (r_key == i_key);

    // The first matching entry claims the wave; otherwise track the lowest stamp.
    always_comb begin
        n_wave = i_wave;
        n_idx  = i_idx;
        if (i_wave.valid && !i_wave.hit) begin
            if (match) begin
                n_wave.hit   = 1'b1;
                n_wave.stamp = r_stamp;
                n_idx        = MY_IDX;
            end else if (!i_wave.seen || (r_stamp < i_wave.stamp)) begin
                n_wave.seen  = 1'b1;
                n_wave.stamp = r_stamp;
                n_idx        = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_stamp <= '0;
        end else if (i_upd.en && (i_upd_idx == MY_IDX)) begin
            r_key   <= i_upd.key;
            r_stamp <= i_upd.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= n_wave.valid;
        end
        r_wave.hit   <= n_wave.hit;
        r_wave.seen  <= n_wave.seen;
        r_wave.stamp <= n_wave.stamp;
        r_idx        <= n_idx;
    end

    assign o_wave = r_wave;
    assign o_idx  = r_idx;

endmodule

`default_nettype wire

// ----- rtl/core/recent_key_dedup_table_top.sv -----
// Top level of the recent-key dedup table: control, output register and APB window register.
// Depends on rkd_pkg and rkd_cell.
//
// Usage:
// The input channel (i_in_valid, o_in_stall) carries one transaction per sighting: a 64-bit
// object key and a 32-bit millisecond time. The output channel (o_out_valid, i_out_stall)
// returns one transaction per input with the is_news flag. The window is written over the
// APB port at byte address 0; pready is always high.
// A nonzero key starts a search wave that walks the row of ENTRIES cells, one cell per
// cycle. When the wave leaves the last cell, the result and the table write-back are
// registered, and the result then goes to the output register. A zero key skips the search
// and goes straight to the finish state with is_news low.
// The cell row sets the search time: the wave must pass every entry before the match or the
// replacement victim is known.
// The block takes one transaction at a time; o_in_stall is high while it works on one.
// When the receiver stalls, the result waits in the output register, and a finished search
// waits for that register before the next transaction is taken.
// Reset clears all keys and stamps to zero, sets the window to 10000 ms and empties both
// channels.
`default_nettype none

module recent_key_dedup_table_top
    import rkd_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [KEY_W-1:0]   i_object_key,
    input  wire logic [STAMP_W-1:0] i_now_ms,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_is_news,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int IDX_W = $clog2(ENTRIES);

    t_state             r_state;
    t_state             n_state;
    logic [KEY_W-1:0]   r_key;
    logic [STAMP_W-1:0] r_now;
    logic [STAMP_W-1:0] r_window;
    logic               r_start;
    logic               n_start;
    logic               r_res;
    logic               n_res;
    t_upd               r_upd;
    t_upd               n_upd;
    logic [IDX_W-1:0]   r_upd_idx;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_is_news;
    logic               n_is_news;
    logic               in_accept;
    logic               load_out;
    logic [STAMP_W-1:0] age;
    logic [ENTRIES:0]   wave_vld;

    t_wave              wave [ENTRIES+1];
    logic [IDX_W-1:0]   widx [ENTRIES+1];

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_WINDOW) ? r_window : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
        end else if (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_WINDOW)) begin
            r_window <= pwdata;
        end
    end

    assign wave[0] = '{valid: r_start, hit: 1'b0, seen: 1'b0, stamp: '0};
    assign widx[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        rkd_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_key     (r_key),
            .i_wave    (wave[g]),
            .i_idx     (widx[g]),
            .o_wave    (wave[g+1]),
            .o_idx     (widx[g+1]),
            .i_upd     (r_upd),
            .i_upd_idx (r_upd_idx)
        );
    end

    for (genvar v = 0; v <= ENTRIES; v++) begin : g_vld
        assign wave_vld[v] = wave[v].valid;
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign age = r_now - wave[ENTRIES].stamp;
    assign load_out = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_res       = r_res;
        n_upd       = r_upd;
        n_upd.en    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_is_news   = r_is_news;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_object_key == '0) begin
                        n_res   = 1'b0;
                        n_state = ST_FINISH;
                    end else begin
                        n_start = 1'b1;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (wave[ENTRIES].valid) begin
                    n_res       = wave[ENTRIES].hit ? (age >= r_window) : 1'b1;
                    n_upd.en    = 1'b1;
                    n_upd.key   = r_key;
                    n_upd.stamp = r_now;
                    n_state     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_is_news   = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_upd.en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_upd.en    <= n_upd.en;
            r_out_valid <= n_out_valid;
        end
        r_upd.key   <= n_upd.key;
        r_upd.stamp <= n_upd.stamp;
        r_res       <= n_res;
        r_is_news   <= n_is_news;
        if (r_state == ST_SEARCH) begin
            r_upd_idx <= widx[ENTRIES];
        end
        if (in_accept) begin
            r_key <= i_object_key;
            r_now <= i_now_ms;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_news   = r_is_news;

`ifndef SYNTHESIS
    a_one_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wave_vld))
        else $error("More than one search wave is in flight.");

    a_start_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == ST_SEARCH))
        else $error("A search wave started outside the search state.");

    a_upd_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upd.en |-> (r_state == ST_FINISH) && $past(wave[ENTRIES].valid))
        else $error("A table write was issued without a finished search.");

    a_nonzero_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_object_key != '0) |=> r_start)
        else $error("A nonzero key did not start a search wave.");
`endif

endmodule

`default_nettype wire

// ----- test/recent_key_dedup_table_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for recent_key_dedup_table_top: directed and random sightings, with the window
// register set over APB, checked against a behavioral copy of the key table in the bench.
// Depends on rkd_pkg and the RTL of the block.

module recent_key_dedup_table_top_tb;
    import rkd_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;
    localparam int POOL_SIZE = 12;
    localparam int RANDOM_PER_PHASE = 110;
    localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_WINDOW, 2'b00};

    typedef struct {
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] now;
    } t_sighting;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [KEY_W-1:0]   i_object_key = '0;
    logic [STAMP_W-1:0] i_now_ms = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_is_news;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    t_sighting          sighting_q[$];
    t_sighting          next_sighting;
    logic               news_q[$];
    logic               want_news;

    logic [KEY_W-1:0]   seen_key[ENTRIES];
    logic [STAMP_W-1:0] seen_stamp[ENTRIES];
    logic [STAMP_W-1:0] window_ms = WINDOW_RST;

    logic [KEY_W-1:0]   key_pool[POOL_SIZE];
    logic [STAMP_W-1:0] clock_ms = '0;
    logic [PDATA_W-1:0] apb_rdata;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    logic drain_hold = 1'b0;
    int mismatches = 0;
    int results_checked = 0;
    int news_count = 0;

    recent_key_dedup_table_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_object_key(i_object_key),
        .i_now_ms    (i_now_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_is_news   (o_is_news),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timed out waiting for the block to drain.");
        $display("Mismatches found");
        $finish;
    end

    initial begin
        for (int slot = 0; slot < ENTRIES; slot++) begin
            seen_key[slot] = '0;
            seen_stamp[slot] = '0;
        end
    end

    // A hit refreshes the stamp; a miss replaces the entry with the lowest stamp.
    function automatic logic predict_news(input logic [KEY_W-1:0] key,
                                          input logic [STAMP_W-1:0] now);
        int victim;
        logic [STAMP_W-1:0] age;
        victim = 0;
        if (key == '0) return 1'b0;
        for (int slot = 0; slot < ENTRIES; slot++) begin
            if (seen_key[slot] != '0 && seen_key[slot] == key) begin
                age = now - seen_stamp[slot];
                seen_stamp[slot] = now;
                return age >= window_ms;
            end
            if (seen_stamp[slot] < seen_stamp[victim]) victim = slot;
        end
        seen_key[victim] = key;
        seen_stamp[victim] = now;
        return 1'b1;
    endfunction

    function automatic void add_sighting(input logic [KEY_W-1:0] key,
                                         input logic [STAMP_W-1:0] now);
        t_sighting s;
        s.key = key;
        s.now = now;
        sighting_q.push_back(s);
    endfunction

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apb_rdata = prdata;
        if (wr && addr[PADDR_W-1:2] == REG_WINDOW) window_ms = data;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_window();
        apb_access(1'b0, WINDOW_ADDR, '0);
        if (apb_rdata !== window_ms) begin
            $display("%0t: window readback mismatch, expected %0d, got %0d",
                     $time, window_ms, apb_rdata);
            mismatches++;
        end
    endtask

    task automatic set_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        apb_access(1'b1, addr, data);
        check_window();
    endtask

    // Most sightings reuse a small pool of keys so that hits, window expiry and
    // eviction all happen; the rest are empty keys and fresh keys, and some sightings jump the time.
    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [STAMP_W-1:0] step_max);
        int pick;
        logic [KEY_W-1:0] key;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 5) key = '0;
            else if (pick < 12) key = {$urandom, $urandom};
            else key = key_pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(99) < 3) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, step_max);
            add_sighting(key, clock_ms);
        end
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        do @(negedge i_clk); while (sighting_q.size() != 0 || news_q.size() != 0 || i_in_valid);
        sender_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                news_q.push_back(predict_news(i_object_key, i_now_ms));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (drain_hold && news_q.size() == 0) begin
                    drain_hold = 1'b0;
                end else if (!drain_hold && sighting_q.size() != 0 && $urandom_range(99) < 2) begin
                    drain_hold = 1'b1;
                end
                if (sighting_q.size() != 0 && !drain_hold &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    next_sighting = sighting_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_object_key <= next_sighting.key;
                    i_now_ms <= next_sighting.now;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (news_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, got is_news %0b",
                             $time, o_is_news);
                    mismatches++;
                end else begin
                    want_news = news_q.pop_front();
                    if (o_is_news !== want_news) begin
                        $display("%0t: is_news mismatch, expected %0b, got %0b",
                                 $time, want_news, o_is_news);
                        mismatches++;
                    end
                    results_checked++;
                    if (want_news) news_count++;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_window();

        // Empty keys, ties on a zero stamp, the exact window edge and stamp wrap.
        add_sighting('0, '0);
        add_sighting(64'h0000_0000_6361_6E31, 32'd0);
        add_sighting(64'h0000_0000_6361_6E32, 32'd0);
        add_sighting(64'h0000_0000_6361_6E31, 32'd0);
        add_sighting(64'h0000_0000_6361_6E31, 32'd9999);
        add_sighting(64'h0000_0000_6361_6E31, 32'd19999);
        add_sighting('1, '1);
        add_sighting('1, 32'd9998);
        add_sighting('1, 32'd19998);
        add_sighting('0, '1);
        add_sighting(64'h1, 32'h1);
        add_sighting(64'h8000_0000_0000_0000, 32'h8000_0000);
        add_sighting(64'h0000_0000_6361_6E31, 32'd19999);
        clock_ms = 32'd20000;
        run_phase(0, 0, 32'd1500);

        set_register(SPARE_ADDR, 32'd5);
        set_register(WINDOW_ADDR, 32'd0);
        clock_ms = clock_ms + 32'd100;
        add_sighting(64'h0123_4567_89AB_CDEF, clock_ms);
        add_sighting(64'h0123_4567_89AB_CDEF, clock_ms);
        run_phase(71, 0, 32'd5000);

        set_register(WINDOW_ADDR, '1);
        add_sighting(64'hFEDC_BA98_7654_3210, 32'd100);
        add_sighting(64'hFEDC_BA98_7654_3210, 32'd99);
        add_sighting(64'hFEDC_BA98_7654_3210, 32'd97);
        clock_ms = 32'hFFFF_C000;
        run_phase(0, 71, 32'd1000);

        set_register(WINDOW_ADDR, $urandom_range(500, 20000));
        run_phase(36, 36, window_ms / 6 + 1);

        repeat (ENTRIES + 4) @(posedge i_clk);
        $display("Checked %0d sightings, %0d of them news, over four idle and stall settings",
                 results_checked, news_count);
        $display("with windows of zero, the reset value, all ones and a random value.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
